FILE: src/stereo_flanger_macros.svh
// Assertion macros for the stereo flanger.
`ifndef STEREO_FLANGER_MACROS_SVH
`define STEREO_FLANGER_MACROS_SVH
`ifndef SYNTH
`define SF_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: src/sflg_pkg.sv
package sflg_pkg;
  typedef struct packed {
    logic signed [23:0] in_left;
    logic signed [23:0] in_right;
  } in_word_t;
  typedef struct packed {
    logic signed [23:0] out_left;
    logic signed [23:0] out_right;
  } out_word_t;
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 25;
  localparam logic [2:0] REG_LFO_STEP = 3'd0;
  localparam logic [2:0] REG_LFO_DEPTH = 3'd1;
  localparam logic [2:0] REG_FEEDBACK = 3'd2;
  localparam logic [2:0] REG_CENTER = 3'd3;
  localparam logic [2:0] REG_WET = 3'd4;
  localparam logic [2:0] REG_MONO = 3'd5;
  // Quarter-wave sine polynomial for table index k of size n.
  function automatic logic [15:0] quarter_sine(input logic [12:0] k, input int unsigned n);
    logic [63:0] x, x2, t, t2, s;
    x = (64'(k) * 64'd65536) / 64'(n);
    x2 = (x * x) >> 16;
    t = 64'd42109 - ((x2 * 64'd4732) >> 16);
    t2 = 64'd102919 - ((x2 * t) >> 16);
    s = (x * t2) >> 17;
    if (s > 64'd32767) s = 64'd32767;
    return s[15:0];
  endfunction
  // Lane control shared by both channels for one word.
  typedef struct packed {
    logic        start;
    logic [7:0]  frac;
    logic signed [15:0] fb;
    logic [16:0] wet;
    logic [16:0] dry;
  } lane_ctl_t;
endpackage

FILE: src/sflg_lane.sv
module sflg_lane #(
  parameter int unsigned LINE_DEPTH = 2048,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  input  sflg_pkg::lane_ctl_t ctl,
  input  logic [$clog2(LINE_DEPTH)-1:0] rd_index,
  input  logic [$clog2(LINE_DEPTH)-1:0] wr_index,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic clear_en,
  input  logic [$clog2(LINE_DEPTH)-1:0] clear_index,
  output logic signed [SAMPLE_BITS-1:0] result,
  output logic done
);
  import sflg_pkg::*;
  localparam int unsigned AW = $clog2(LINE_DEPTH);
  localparam int unsigned SB = SAMPLE_BITS;
  localparam logic signed [SB+33:0] HI = (SB+34)'((64'd1 << (SB-1)) - 1);
  localparam logic signed [SB+33:0] LO = -HI - 1;

  logic signed [SB-1:0] mem [LINE_DEPTH];
  logic signed [SB-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic [5:0] phase;
  logic signed [SB-1:0] s0, s1;
  logic signed [SB+9:0] acc;
  logic signed [SB+1:0] delayed;
  logic signed [SB+17:0] fbp;
  logic signed [SB+33:0] mixp;
  logic signed [SB+33:0] wsum;

  function automatic logic signed [SB-1:0] sat(input logic signed [SB+33:0] v);
    if (v > HI) return HI[SB-1:0];
    if (v < LO) return LO[SB-1:0];
    return v[SB-1:0];
  endfunction

  always_comb begin
    rd_addr = phase[0] ? rd_index + AW'(1) : rd_index;
  end

  always_comb begin
    acc = (SB+10)'(s0) * $signed({1'b0, 9'd256 - 9'(ctl.frac)})
        + (SB+10)'(s1) * $signed({1'b0, 1'b0, ctl.frac});
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (clear_en) begin
      mem[clear_index] <= '0;
    end else if (phase[5]) begin
      mem[wr_index] <= sat(wsum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else begin
      phase <= {phase[4:0], ctl.start};
    end
  end

  always_ff @(posedge clk) begin
    if (phase[0]) s0 <= rd_data;
    if (phase[1]) begin
      s1 <= rd_data;
    end
    if (phase[3]) begin
      delayed <= (SB+2)'(acc >>> 8);
    end
    if (phase[4]) begin
      fbp <= delayed * ctl.fb;
      mixp <= (SB+34)'(delayed) * $signed({1'b0, ctl.wet})
            + (SB+34)'(sample) * $signed({1'b0, ctl.dry});
    end
  end

  assign wsum = (SB+34)'(sample) + (SB+34)'(fbp >>> 15);
  assign result = sat(mixp >>> 15);
  assign done = phase[5];
endmodule

FILE: src/stereo_flanger.sv
// Stereo flanger.
// The input channel (in_valid, in_stall, in_data) takes one stereo sample
// word; the output channel (out_valid, out_stall, out_data) returns one
// flanged stereo word for each input word, in order.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while the block is idle, which the block itself does
// not enforce. Unknown indexes are ignored. For each word the LFO sine and
// delay arithmetic come first, then the two interpolation reads and the mix
// in each channel lane. The two delay-line memories run in parallel lanes,
// one per channel, and the lanes are merged into one output word.
// One word is in flight at a time: no new word is accepted until the last
// output word has been taken.
// After reset both delay lines are swept to zero, one entry per cycle; no
// word is accepted during the sweep.
// When the receiver stalls, the output word holds and no new input word is
// accepted until the held word has been taken.
module stereo_flanger #(
  parameter int unsigned LINE_DEPTH = 2048,
  parameter int unsigned SINE_TABLE_SIZE = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sflg_pkg::in_word_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output sflg_pkg::out_word_t out_data,
  input  logic cfg_we,
  input  logic [sflg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [sflg_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import sflg_pkg::*;
`include "stereo_flanger_macros.svh"
  localparam int unsigned AW = $clog2(LINE_DEPTH);
  localparam int unsigned TW = $clog2(SINE_TABLE_SIZE);
  localparam int unsigned SPAN_BITS = AW + 8;
  localparam logic [SPAN_BITS-1:0] DMAX = SPAN_BITS'((LINE_DEPTH - 2) * 256);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_CALC  = 5'b00100,
    S_LANE  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state;
  logic [24:0] lfo_step;
  logic [15:0] lfo_depth;
  logic signed [15:0] feedback_gain;
  logic [17:0] center_delay;
  logic [15:0] wet_mix;
  logic mono_input;
  logic [AW-1:0] write_index;
  logic [31:0] lfo_phase;
  logic [AW-1:0] clear_index;
  logic [2:0] calc_step;
  logic signed [23:0] smp_l, smp_r;
  logic signed [16:0] sine;
  logic [33:0] range;
  logic signed [51:0] modp;
  logic [SPAN_BITS-1:0] rp;
  logic [SPAN_BITS-1:0] rp_next;
  logic [AW-1:0] rd_index;
  lane_ctl_t ctl;
  logic signed [23:0] res_l, res_r;
  logic done_l, done_r;

  logic [15:0] sine_rom [SINE_TABLE_SIZE+1];
  logic [TW:0] k;
  logic [15:0] qv;
  logic [16:0] depth_c, wet_c;
  logic signed [52:0] dsum;
  logic [SPAN_BITS-1:0] dclamp;

  for (genvar gi = 0; gi <= SINE_TABLE_SIZE; gi++) begin : g_sine
    assign sine_rom[gi] = quarter_sine(13'(gi), SINE_TABLE_SIZE);
  end

  always_comb begin
    k = (TW+1)'(lfo_phase[29:30-TW]);
    if (lfo_phase[30]) k = (TW+1)'(SINE_TABLE_SIZE) - k;
    qv = sine_rom[k];
    depth_c = (lfo_depth > 16'd32768) ? 17'd32768 : 17'(lfo_depth);
    wet_c = (wet_mix > 16'd32768) ? 17'd32768 : 17'(wet_mix);
    dsum = 53'(center_delay) + 53'(modp >>> 15);
    if (dsum > $signed(53'(DMAX))) dclamp = DMAX;
    else if (dsum < 0) dclamp = '0;
    else dclamp = dsum[SPAN_BITS-1:0];
    rp_next = SPAN_BITS'({write_index, 8'd0}) - dclamp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clear_index <= '0;
      write_index <= '0;
      lfo_phase <= '0;
      out_valid <= 1'b0;
      calc_step <= '0;
      ctl.start <= 1'b0;
      lfo_step <= 25'd44739;
      lfo_depth <= 16'd22938;
      feedback_gain <= 16'sd16384;
      center_delay <= 18'd61440;
      wet_mix <= 16'd16384;
      mono_input <= 1'b0;
    end else begin
      ctl.start <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LFO_STEP:  lfo_step <= cfg_data;
          REG_LFO_DEPTH: lfo_depth <= cfg_data[15:0];
          REG_FEEDBACK:  feedback_gain <= cfg_data[15:0];
          REG_CENTER:    center_delay <= cfg_data[17:0];
          REG_WET:       wet_mix <= cfg_data[15:0];
          REG_MONO:      mono_input <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          clear_index <= clear_index + AW'(1);
          if (clear_index == AW'(LINE_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            smp_l <= in_data.in_left;
            smp_r <= mono_input ? in_data.in_left : in_data.in_right;
            sine <= lfo_phase[31] ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
            range <= (34'(center_delay) * 34'(depth_c)) >> 15;
            calc_step <= '0;
            state <= S_CALC;
          end
        end
        S_CALC: begin
          calc_step <= calc_step + 3'd1;
          if (calc_step == 3'd0) begin
            modp <= $signed({1'b0, range[19:0]}) * sine;
          end else begin
            rp <= rp_next;
            ctl.frac <= rp_next[7:0];
            ctl.start <= 1'b1;
            ctl.fb <= feedback_gain;
            ctl.wet <= wet_c;
            ctl.dry <= 17'd32768 - wet_c;
            state <= S_LANE;
          end
        end
        S_LANE: begin
          if (done_l && done_r) begin
            write_index <= write_index + AW'(1);
            lfo_phase <= lfo_phase + 32'(lfo_step);
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rd_index = rp[SPAN_BITS-1:8];
  assign in_stall = (state != S_IDLE);

  sflg_lane #(.LINE_DEPTH(LINE_DEPTH), .SAMPLE_BITS(24)) u_lane_l (
    .clk(clk), .rst(rst), .ctl(ctl), .rd_index(rd_index), .wr_index(write_index),
    .sample(smp_l), .clear_en(state == S_CLEAR), .clear_index(clear_index),
    .result(res_l), .done(done_l)
  );

  sflg_lane #(.LINE_DEPTH(LINE_DEPTH), .SAMPLE_BITS(24)) u_lane_r (
    .clk(clk), .rst(rst), .ctl(ctl), .rd_index(rd_index), .wr_index(write_index),
    .sample(smp_r), .clear_en(state == S_CLEAR), .clear_index(clear_index),
    .result(res_r), .done(done_r)
  );

  always_ff @(posedge clk) begin
    if (state == S_LANE && done_l && done_r) begin
      out_data.out_left <= res_l;
      out_data.out_right <= res_r;
    end
  end

  `SF_ASSERT_IMPL(a_lanes_sync, clk, rst, done_l, done_r)
  `SF_ASSERT_IMPL(a_no_accept_busy, clk, rst, out_valid, in_stall)
  `SF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
endmodule

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sflg_pkg::*;

  localparam int DEPTH = 2048;
  localparam int WATCH_LIMIT = 20000;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  stereo_flanger dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  int left_mem[DEPTH];
  int right_mem[DEPTH];
  bit [10:0] wr_ptr;
  bit [31:0] phase;
  bit [24:0] step_r = 25'd44739;
  bit [15:0] depth_r = 16'd22938;
  bit [15:0] fb_r = 16'd16384;
  bit [17:0] center_r = 18'd61440;
  bit [15:0] wet_r = 16'd16384;
  bit mono_r = 1'b0;

  in_word_t pending_words[$];
  out_word_t expected_words[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int recv_hold = 0;
  bit burst = 1'b0;

  function automatic longint clip24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint table_sine(longint unsigned k);
    longint unsigned x, x2, t, t2, s;
    x = k * 65536 / 256;
    x2 = (x * x) >> 16;
    t = 42109 - ((x2 * 4732) >> 16);
    t2 = 102919 - ((x2 * t) >> 16);
    s = (x * t2) >> 17;
    if (s > 32767) s = 32767;
    return longint'(s);
  endfunction

  function automatic longint lfo_value(bit [31:0] ph);
    longint unsigned k;
    longint v;
    k = longint'(ph[29:22]);
    if (ph[30]) k = 256 - k;
    v = table_sine(k);
    return ph[31] ? -v : v;
  endfunction

  function automatic longint tap_read(ref int mem[DEPTH], input longint d);
    longint rp, i0, i1, f;
    rp = (longint'(wr_ptr) * 256 + DEPTH * 256 - d) % (DEPTH * 256);
    i0 = (rp >> 8) % DEPTH;
    i1 = (i0 + 1) % DEPTH;
    f = rp & 255;
    return (longint'(mem[i0]) * (256 - f) + longint'(mem[i1]) * f) >>> 8;
  endfunction

  task automatic flange_predict(input in_word_t w);
    longint il, ir, dep, wet, dry, fb, ctr, range, d, dl, dr;
    out_word_t r;
    il = longint'(w.in_left);
    ir = mono_r ? il : longint'(w.in_right);
    dep = (depth_r > 16'd32768) ? 32768 : longint'(depth_r);
    wet = (wet_r > 16'd32768) ? 32768 : longint'(wet_r);
    dry = 32768 - wet;
    fb = longint'($signed(fb_r));
    ctr = longint'(center_r);
    range = (ctr * dep) >>> 15;
    d = ctr + ((range * lfo_value(phase)) >>> 15);
    if (d > (DEPTH - 2) * 256) d = (DEPTH - 2) * 256;
    if (d < 0) d = 0;
    dl = tap_read(left_mem, d);
    dr = tap_read(right_mem, d);
    left_mem[wr_ptr] = int'(clip24(il + ((dl * fb) >>> 15)));
    right_mem[wr_ptr] = int'(clip24(ir + ((dr * fb) >>> 15)));
    wr_ptr = wr_ptr + 11'd1;
    phase = phase + 32'(step_r);
    r.out_left = 24'(clip24((il * dry + dl * wet) >>> 15));
    r.out_right = 24'(clip24((ir * dry + dr * wet) >>> 15));
    expected_words.push_back(r);
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input longint val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_BITS'(val);
    case (idx)
      REG_LFO_STEP: step_r = 25'(val);
      REG_LFO_DEPTH: depth_r = 16'(val);
      REG_FEEDBACK: fb_r = 16'(val);
      REG_CENTER: center_r = 18'(val);
      REG_WET: wet_r = 16'(val);
      REG_MONO: mono_r = 1'(val);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (pending_words.size() != 0 || expected_words.size() != 0 || in_valid)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic queue_word(input longint l, input longint r);
    in_word_t w;
    w.in_left = 24'(l);
    w.in_right = 24'(r);
    pending_words.push_back(w);
  endtask

  task automatic queue_random(input int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) queue_word($urandom, $urandom);
      else if (sel < 8) queue_word($signed(12'($urandom)), $signed(12'($urandom)));
      else queue_word($urandom_range(0, 1) ? 8388607 : -8388608,
                      $urandom_range(0, 1) ? 8388607 : -8388608);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
    end else begin
      if (in_valid) begin
        flange_predict(in_data);
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_data <= pending_words.pop_front();
        in_valid <= 1'b1;
        send_gap <= burst ? 0 : $urandom_range(0, 19);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report("unexpected word", out_data.out_left, 0);
      end else begin
        out_word_t e;
        e = expected_words.pop_front();
        if (out_data.out_left !== e.out_left) report("out_left", out_data.out_left, e.out_left);
        if (out_data.out_right !== e.out_right)
          report("out_right", out_data.out_right, e.out_right);
      end
      recv_hold = burst ? 0 : $urandom_range(0, 19);
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold = recv_hold - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    longint cfg_sets[9][6];
    cfg_sets = '{
      '{0, 0, 0, 256, 0, 0},
      '{33554431, 65535, 32768, 262143, 65535, 1},
      '{16777216, 32768, 31130, 256000, 32768, 0},
      '{1234567, 16384, -31130, 0, 8192, 1},
      '{44739, 32768, 32767, 120000, 24576, 0},
      '{8388608, 40000, -32768, 256000, 40000, 0},
      '{0, 0, 31130, 524, 16384, 0},
      '{21845, 30000, -20000, 30000, 32768, 1},
      '{44739, 22938, 16384, 61440, 16384, 0}
    };
    for (int i = 0; i < DEPTH; i++) begin
      left_mem[i] = 0;
      right_mem[i] = 0;
    end
    wr_ptr = '0;
    phase = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    queue_word(8388607, -8388608);
    queue_word(-8388608, 8388607);
    queue_word(0, 0);
    queue_word(-1, 1);
    queue_word(8388607, 8388607);
    queue_word(-8388608, -8388608);
    for (int i = 0; i < 14; i++) queue_word((i % 2) ? 8388607 : -8388608, 4096 * i);
    settle();

    for (int p = 0; p < 12; p++) begin
      if (p < 9) begin
        for (int r = 0; r < 6; r++) write_reg(CFG_INDEX_BITS'(r), cfg_sets[p][r]);
      end else begin
        write_reg(REG_LFO_STEP, $urandom_range(0, 16777216));
        write_reg(REG_LFO_DEPTH, $urandom_range(0, 65535));
        write_reg(REG_FEEDBACK, $signed(16'($urandom)));
        write_reg(REG_CENTER, $urandom_range(0, 262143));
        write_reg(REG_WET, $urandom_range(0, 65535));
        write_reg(REG_MONO, $urandom_range(0, 1));
      end
      write_reg(REG_SPARE_LO, $urandom);
      write_reg(REG_SPARE_HI, $urandom);
      burst = (p % 4 == 3);
      queue_random(120);
      settle();
    end
    burst = 1'b0;
    settle();
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
